// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the blend segment resolver RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blend_segment_resolve: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blend_segment_resolve: assertion failed");

`endif

// ===== hw/rtl/bsr_pkg.sv =====
// Types and constants shared by the blend segment resolver modules.
// No dependencies.
`default_nettype none

package bsr_pkg;

    localparam int POS_W      = 16;
    localparam int CLIP_W     = 10;
    localparam int WEIGHT_W   = 16;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int DIFF_W     = POS_W + 1;
    localparam int REM_W      = 32;
    localparam int STEP_W     = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    // What the walk has found so far for the token in flight
    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_SINGLE,
        TOK_PAIR
    } tok_kind_t;

    typedef struct packed {
        logic                     valid;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  prev_pos;
        logic [CLIP_W-1:0]        prev_clip;
        tok_kind_t                kind;
        logic signed [POS_W-1:0]  a_pos;
        logic [CLIP_W-1:0]        a_clip;
        logic signed [POS_W-1:0]  b_pos;
        logic [CLIP_W-1:0]        b_clip;
    } tok_t;

    typedef struct packed {
        logic wr_en;
        logic first;
        logic active;
        logic last;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        DIV_LOW,
        DIV_HIGH,
        DIV_BLEND
    } div_kind_t;

    typedef struct packed {
        logic                  done;
        div_kind_t             kind;
        logic [WEIGHT_W-1:0]   quotient;
    } div_res_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN
    } div_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_WALK,
        CS_DIV,
        CS_DONE
    } ctl_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blend_segment_resolve.sv =====
// Path to tvalid: a blend or a weight that truncates to zero runs the whole serial divide;
// a zero span, a zero offset or a query on the upper sample ends at the divider's check;
// the walk alone settles the rest, and a query on an empty table skips the walk.
// Throughput: one item at a time, set by the walk through the chain of MAX_SAMPLES cells
// and the 16-step serial divider; a held result stalls the next one. A write leaves it idle.
// Reset: rst_n clears control and sample_count; table entries are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module blend_segment_resolve #(
    parameter int MAX_SAMPLES = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration: sample_count
    input  wire                                   cfg_wr_en,
    input  wire  [bsr_pkg::COUNT_W-1:0]           cfg_wr_data,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_index[3:0], sample_pos[19:4], sample_clip[29:20], query_x[45:30], zero pad
    input  wire  [bsr_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // operation[0]
    input  wire                                   s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // clip_a[9:0], clip_b[19:10], weight[35:20], zero pad
    output logic [bsr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // no_samples[0]
    output logic                                  m_axis_tuser
);
    import bsr_pkg::*;

    // Unpack the input transfer
    logic [INDEX_W-1:0]      in_index;
    logic [POS_W-1:0]        in_pos;
    logic [CLIP_W-1:0]       in_clip;
    logic signed [POS_W-1:0] in_x;
    logic                    in_fire;
    logic                    wr_fire;
    logic                    query_fire;

    assign in_index   = s_axis_tdata[3:0];
    assign in_pos     = s_axis_tdata[19:4];
    assign in_clip    = s_axis_tdata[29:20];
    assign in_x       = s_axis_tdata[45:30];
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign wr_fire    = in_fire && (s_axis_tuser == OP_WRITE);
    assign query_fire = in_fire && (s_axis_tuser == OP_RESOLVE);

    ctl_state_t              state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [CLIP_W-1:0]       res_clip_a_reg, res_clip_a_next;
    logic [CLIP_W-1:0]       res_clip_b_reg, res_clip_b_next;
    logic [WEIGHT_W-1:0]     res_weight_reg, res_weight_next;
    logic                    res_empty_reg, res_empty_next;
    logic [CLIP_W-1:0]       pair_a_clip_reg, pair_a_clip_next;
    logic [CLIP_W-1:0]       pair_b_clip_reg, pair_b_clip_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_user_reg, out_user_next;

    // Chain of cells: token enters at the head, one cell per cycle
    tok_t      tok_chain [0:MAX_SAMPLES];
    cell_ctl_t cell_ctl  [0:MAX_SAMPLES-1];
    tok_t      tail;

    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = query_fire && (count_reg != '0);
        tok_chain[0].x     = in_x;
        tok_chain[0].kind  = TOK_NONE;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SAMPLES; g++)
        begin : g_cell
            // entry is live below the (clamped) count; the last live entry closes the walk
            assign cell_ctl[g] = '{
                wr_en:  wr_fire && (32'(in_index) == g),
                first:  (g == 0),
                active: (32'(count_reg) > g),
                last:   (32'(count_reg) == g + 1)
                        || ((g == MAX_SAMPLES - 1) && (32'(count_reg) > MAX_SAMPLES))
            };

            bsr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl[g]),
                .wr_pos  (in_pos),
                .wr_clip (in_clip),
                .tok_in  (tok_chain[g]),
                .tok_out (tok_chain[g+1])
            );
        end
    endgenerate

    assign tail = tok_chain[MAX_SAMPLES];

    // Weight divider: num = x - a, span = b - a, both as 17-bit differences
    logic                     div_start;
    logic signed [DIFF_W-1:0] div_num;
    logic signed [DIFF_W-1:0] div_span;
    div_res_t                 div_res;

    assign div_start = (state_reg == CS_WALK) && tail.valid && (tail.kind == TOK_PAIR);
    assign div_num   = {tail.x[POS_W-1], tail.x} - {tail.a_pos[POS_W-1], tail.a_pos};
    assign div_span  = {tail.b_pos[POS_W-1], tail.b_pos} - {tail.a_pos[POS_W-1], tail.a_pos};

    bsr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .span  (div_span),
        .res   (div_res)
    );

    // Sequencer: take one query, walk, divide if bracketed, hand the result to the output register
    always_comb
    begin
        state_next       = state_reg;
        count_next       = cfg_wr_en ? cfg_wr_data : count_reg;
        res_clip_a_next  = res_clip_a_reg;
        res_clip_b_next  = res_clip_b_reg;
        res_weight_next  = res_weight_reg;
        res_empty_next   = res_empty_reg;
        pair_a_clip_next = pair_a_clip_reg;
        pair_b_clip_next = pair_b_clip_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;

        // drop the held result once the sink takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            CS_IDLE:
            begin
                if (query_fire)
                begin
                    if (count_reg == '0)
                    begin
                        res_clip_a_next = '0;
                        res_clip_b_next = '0;
                        res_weight_next = '0;
                        res_empty_next  = 1'b1;
                        state_next      = CS_DONE;
                    end
                    else
                    begin
                        state_next = CS_WALK;
                    end
                end
            end
            CS_WALK:
            begin
                if (tail.valid)
                begin
                    if (tail.kind == TOK_PAIR)
                    begin
                        pair_a_clip_next = tail.a_clip;
                        pair_b_clip_next = tail.b_clip;
                        state_next       = CS_DIV;
                    end
                    else
                    begin
                        res_clip_a_next = tail.a_clip;
                        res_clip_b_next = tail.a_clip;
                        res_weight_next = '0;
                        res_empty_next  = 1'b0;
                        state_next      = CS_DONE;
                    end
                end
            end
            CS_DIV:
            begin
                if (div_res.done)
                begin
                    res_empty_next = 1'b0;
                    case (div_res.kind)
                        DIV_HIGH:
                        begin
                            res_clip_a_next = pair_b_clip_reg;
                            res_clip_b_next = pair_b_clip_reg;
                            res_weight_next = '0;
                        end
                        DIV_BLEND:
                        begin
                            res_clip_a_next = pair_a_clip_reg;
                            res_clip_b_next = pair_b_clip_reg;
                            res_weight_next = div_res.quotient;
                        end
                        default:
                        begin
                            res_clip_a_next = pair_a_clip_reg;
                            res_clip_b_next = pair_a_clip_reg;
                            res_weight_next = '0;
                        end
                    endcase
                    state_next = CS_DONE;
                end
            end
            CS_DONE:
            begin
                // advance only when the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {(OUT_DATA_W - 2*CLIP_W - WEIGHT_W)'(0),
                                      res_weight_reg, res_clip_b_reg, res_clip_a_reg};
                    out_user_next  = res_empty_reg;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_clip_a_reg  <= res_clip_a_next;
        res_clip_b_reg  <= res_clip_b_next;
        res_weight_reg  <= res_weight_next;
        res_empty_reg   <= res_empty_next;
        pair_a_clip_reg <= pair_a_clip_next;
        pair_b_clip_reg <= pair_b_clip_next;
        out_data_reg    <= out_data_next;
        out_user_reg    <= out_user_next;
    end

    assign s_axis_tready = (state_reg == CS_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // A token only reaches the tail while the sequencer waits for it
    `BSR_ASSERT_NOW(a_tail_in_walk, clk, rst_n, tail.valid, state_reg == CS_WALK)
    // Divider completion is only seen while the sequencer waits for it
    `BSR_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_res.done, state_reg == CS_DIV)
    // A bracketed query hands over to the divider
    `BSR_ASSERT_NXT(a_pair_to_div, clk, rst_n,
        (state_reg == CS_WALK) && tail.valid && (tail.kind == TOK_PAIR),
        state_reg == CS_DIV)
    // A query on an empty table skips the walk
    `BSR_ASSERT_NXT(a_empty_skips_walk, clk, rst_n,
        query_fire && (count_reg == '0),
        (state_reg == CS_DONE) && res_empty_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/bsr_cell.sv =====
// One table entry of the resolver chain: holds a sample and inspects the passing token.
// Depends on bsr_pkg.
`default_nettype none

module bsr_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire bsr_pkg::cell_ctl_t     ctl,
    input  wire  [bsr_pkg::POS_W-1:0]   wr_pos,
    input  wire  [bsr_pkg::CLIP_W-1:0]  wr_clip,
    input  wire bsr_pkg::tok_t          tok_in,
    output bsr_pkg::tok_t               tok_out
);
    import bsr_pkg::*;

    logic signed [POS_W-1:0] pos_reg;
    logic [CLIP_W-1:0]       clip_reg;
    logic                    valid_reg;
    tok_t                    tok_reg;
    tok_t                    tok_next;

    always_comb
    begin
        tok_next           = tok_in;
        tok_next.prev_pos  = pos_reg;
        tok_next.prev_clip = clip_reg;
        if (ctl.active)
        begin
            if (ctl.first)
            begin
                // at or below the first sample: collapse to it
                if ($signed(tok_in.x) <= $signed(pos_reg))
                begin
                    tok_next.kind   = TOK_SINGLE;
                    tok_next.a_clip = clip_reg;
                end
                else
                begin
                    tok_next.kind = TOK_NONE;
                end
            end
            else if (tok_in.kind == TOK_NONE && $signed(tok_in.x) <= $signed(pos_reg))
            begin
                tok_next.kind   = TOK_PAIR;
                tok_next.a_pos  = tok_in.prev_pos;
                tok_next.a_clip = tok_in.prev_clip;
                tok_next.b_pos  = pos_reg;
                tok_next.b_clip = clip_reg;
            end
            // at or above the last sample overrides any bracket found
            if (ctl.last && tok_next.kind != TOK_SINGLE
                && $signed(tok_in.x) >= $signed(pos_reg))
            begin
                tok_next.kind   = TOK_SINGLE;
                tok_next.a_clip = clip_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            pos_reg  <= wr_pos;
            clip_reg <= wr_clip;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsr_divider.sv =====
// Restoring serial divider for the blend weight: one quotient bit per cycle.
// Depends on bsr_pkg.
`default_nettype none

module bsr_divider (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire signed [bsr_pkg::DIFF_W-1:0]   num,
    input  wire signed [bsr_pkg::DIFF_W-1:0]   span,
    output bsr_pkg::div_res_t                  res
);
    import bsr_pkg::*;

    div_state_t          state_reg, state_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    div_reg, div_next;
    logic [WEIGHT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done_reg, done_next;
    div_kind_t           kind_reg, kind_next;
    logic [REM_W:0]      shifted;
    logic [REM_W:0]      diff;
    logic                qbit;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, div_reg};
    assign qbit    = ~diff[REM_W];

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        kind_next  = kind_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    // operands act as 32-bit unsigned words, as wrapped differences
                    rem_next   = {{(REM_W-DIFF_W){num[DIFF_W-1]}}, num};
                    div_next   = {{(REM_W-DIFF_W){span[DIFF_W-1]}}, span};
                    state_next = DV_CHECK;
                end
            end
            DV_CHECK:
            begin
                if (div_reg == '0 || rem_reg == '0)
                begin
                    kind_next  = DIV_LOW;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else if (rem_reg >= div_reg)
                begin
                    kind_next  = DIV_HIGH;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else
                begin
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next  = qbit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
                quot_next = {quot_reg[WEIGHT_W-2:0], qbit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(WEIGHT_W - 1))
                begin
                    kind_next  = (quot_next == '0) ? DIV_LOW : DIV_BLEND;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        kind_reg <= kind_next;
    end

    assign res = '{done: done_reg, kind: kind_reg, quotient: quot_reg};

endmodule

`default_nettype wire
